>>> rtl/ps2dl_pkg.sv
// ----------------------------------------------------------------------------
// ps2dl_pkg
// Types and constants shared by the PS/2 device link engine: event codes,
// link modes, frame phases, the link state record and the result record.
// ----------------------------------------------------------------------------
package ps2dl_pkg;

    // Event kind carried with each request
    typedef enum logic [1:0] {
        EV_CLK_RISE = 2'd0,
        EV_CLK_FALL = 2'd1,
        EV_DATA_TICK = 2'd2,
        EV_SEND_REQ = 2'd3
    } t_event;

    // Link mode, also reported as link status
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_REQUEST = 2'd1,
        MODE_SEND = 2'd2,
        MODE_RECEIVE = 2'd3
    } t_mode;

    // Position inside a frame
    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_DATA = 3'd1,
        PH_PARITY = 3'd2,
        PH_STOP = 3'd3,
        PH_ACK = 3'd4,
        PH_FINISHED = 3'd5
    } t_phase;

    // Index of the last data bit of a frame
    localparam int unsigned LAST_BIT = 7;

    // Error flag positions
    localparam int unsigned ERR_START = 0;
    localparam int unsigned ERR_PARITY = 1;
    localparam int unsigned ERR_STOP = 2;

    // Link state carried from event to event
    typedef struct packed {
        t_mode mode;
        t_phase phase;
        logic send_pending;
        logic [7:0] tx_shift;
        logic [3:0] bit_index;
        logic parity_acc;
        logic [7:0] rx_shift;
        logic [2:0] error_bits;
    } t_state;

    // One result per event
    typedef struct packed {
        logic clk_write;
        logic clk_level;
        logic data_write;
        logic data_level;
        logic rx_valid;
        logic [7:0] rx_byte;
        logic [2:0] rx_errors;
        logic tx_done;
        t_mode link_status;
    } t_result;

endpackage

>>> rtl/ps2dl_step.sv
// ----------------------------------------------------------------------------
// ps2dl_step
// Next-state and result logic for one link event. Purely combinational:
// takes the current link state and one event, gives the new state and the
// line drive / status result for that event.
// ----------------------------------------------------------------------------
module ps2dl_step
    import ps2dl_pkg::*;
(
    input  t_event     i_func,
    input  logic       i_clk_line,
    input  logic       i_data_line,
    input  logic [7:0] i_send_byte,
    input  t_state     i_state,
    output t_state     o_state,
    output t_result    o_result
);

    t_state  s;
    t_result r;
    logic    tx_bit;
    logic [3:0] bit_next;

    always_comb begin
        s = i_state;
        r = '0;
        tx_bit = 1'b1;
        bit_next = i_state.bit_index + 4'd1;

        unique case (i_func)
            EV_CLK_RISE: begin
                // detect host request: CLK low, then released
                if (s.mode == MODE_IDLE) begin
                    if (!i_clk_line) begin
                        s.mode = MODE_REQUEST;
                    end
                end else if (s.mode == MODE_REQUEST) begin
                    if (i_clk_line) begin
                        s.mode = MODE_RECEIVE;
                        s.phase = PH_START;
                        s.bit_index = '0;
                    end
                end
                // drive CLK high while a frame is active
                if (s.mode == MODE_SEND || s.mode == MODE_RECEIVE) begin
                    r.clk_write = 1'b1;
                    r.clk_level = 1'b1;
                end
                // close a finished transmit frame
                if (s.mode == MODE_SEND && s.phase >= PH_FINISHED) begin
                    s.mode = MODE_IDLE;
                    s.send_pending = 1'b0;
                    r.tx_done = 1'b1;
                end
                // start a pending transmit
                if (s.mode == MODE_IDLE && s.send_pending) begin
                    s.mode = MODE_SEND;
                    s.phase = PH_START;
                end
            end
            EV_CLK_FALL: begin
                // drive CLK low while a frame is active
                if (s.mode == MODE_SEND || s.mode == MODE_RECEIVE) begin
                    r.clk_write = 1'b1;
                    r.clk_level = 1'b0;
                end
                // hand over a finished receive frame
                if (s.mode == MODE_RECEIVE && s.phase >= PH_FINISHED) begin
                    s.mode = MODE_IDLE;
                    r.rx_valid = 1'b1;
                    r.rx_byte = s.rx_shift;
                    r.rx_errors = s.error_bits;
                end
            end
            EV_DATA_TICK: begin
                if (s.mode == MODE_SEND || s.mode == MODE_RECEIVE) begin
                    if (!i_clk_line) begin
                        // host pulled CLK low: release DATA and drop the frame
                        r.data_write = 1'b1;
                        r.data_level = 1'b1;
                        s.mode = MODE_IDLE;
                    end else if (s.mode == MODE_SEND) begin
                        // shift out one transmit bit
                        unique case (s.phase)
                            PH_START: begin
                                s.bit_index = '0;
                                s.parity_acc = 1'b0;
                                tx_bit = 1'b0;
                                s.phase = PH_DATA;
                            end
                            PH_DATA: begin
                                tx_bit = s.tx_shift[s.bit_index[2:0]];
                                s.bit_index = bit_next;
                                s.parity_acc = s.parity_acc ^ tx_bit;
                                if (bit_next > 4'(LAST_BIT)) begin
                                    s.parity_acc = ~s.parity_acc;
                                    s.phase = PH_PARITY;
                                end
                            end
                            PH_PARITY: begin
                                tx_bit = s.parity_acc;
                                s.phase = PH_STOP;
                            end
                            PH_STOP: begin
                                tx_bit = 1'b1;
                                s.phase = PH_FINISHED;
                            end
                            default: begin
                                tx_bit = 1'b1;
                            end
                        endcase
                        r.data_write = 1'b1;
                        r.data_level = tx_bit;
                    end else begin
                        // sample one receive bit, then ack
                        unique case (s.phase)
                            PH_START: begin
                                s.bit_index = '0;
                                s.parity_acc = 1'b0;
                                s.error_bits = '0;
                                s.error_bits[ERR_START] = i_data_line;
                                s.phase = PH_DATA;
                            end
                            PH_DATA: begin
                                s.rx_shift[s.bit_index[2:0]] = i_data_line;
                                s.bit_index = bit_next;
                                s.parity_acc = s.parity_acc ^ i_data_line;
                                if (bit_next > 4'(LAST_BIT)) begin
                                    s.parity_acc = ~s.parity_acc;
                                    s.phase = PH_PARITY;
                                end
                            end
                            PH_PARITY: begin
                                if (i_data_line != s.parity_acc) begin
                                    s.error_bits[ERR_PARITY] = 1'b1;
                                end
                                s.phase = PH_STOP;
                            end
                            PH_STOP: begin
                                if (!i_data_line) begin
                                    s.error_bits[ERR_STOP] = 1'b1;
                                end
                                s.phase = PH_ACK;
                            end
                            PH_ACK: begin
                                r.data_write = 1'b1;
                                r.data_level = 1'b0;
                                s.phase = PH_FINISHED;
                            end
                            default: begin
                                r.data_write = 1'b1;
                                r.data_level = 1'b1;
                            end
                        endcase
                    end
                end
            end
            EV_SEND_REQ: begin
                // latch a byte unless one is already waiting
                if (!s.send_pending) begin
                    s.send_pending = 1'b1;
                    s.tx_shift = i_send_byte;
                end
            end
            default: begin
            end
        endcase

        r.link_status = s.mode;
        o_state = s;
        o_result = r;
    end

endmodule

>>> rtl/ps2_device_link_engine.sv
// ----------------------------------------------------------------------------
// ps2_device_link_engine
// Device side of a PS/2 link that generates the clock itself.
// ----------------------------------------------------------------------------
// Each request is one line event (CLK rise, CLK fall, data tick or send
// request) with the sampled CLK and DATA levels, and gives exactly one
// result: the CLK/DATA drive for that event, a completed received byte with
// its start/parity/stop error flags, a transmit-done flag and the link mode
// after the event. One request is taken every clock cycle unless the result
// side holds back; each request goes through an input register, one pass of
// next-state logic and a result register, which holds the result on the
// output until it is taken. The link state updates in that single pass,
// which is what sets the one-per-cycle rate. Back-pressure on the result
// side stalls the input after the two registers fill.
// ----------------------------------------------------------------------------
module ps2_device_link_engine
    import ps2dl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] clk_line, [1] data_line, [9:2] send_byte, [15:10] zero
    input  logic [15:0] s_axis_tdata,
    // [1:0] func
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] clk_write, [1] clk_level, [2] data_write, [3] data_level,
    // [4] rx_valid, [12:5] rx_byte, [15:13] rx_errors, [16] tx_done,
    // [18:17] link_status, [23:19] zero
    output logic [23:0] m_axis_tdata
);

    logic       r_in_valid;
    t_event     r_func;
    logic       r_clk_line;
    logic       r_data_line;
    logic [7:0] r_send_byte;

    t_state     r_state;
    t_state     n_state;
    t_result    n_result;

    logic       r_out_valid;
    t_result    r_out;

    logic       adv;

    // advance the event stage when the result register can take it
    assign adv = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || !r_out_valid || m_axis_tready;

    // hold the accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_func <= t_event'(s_axis_tuser);
            r_clk_line <= s_axis_tdata[0];
            r_data_line <= s_axis_tdata[1];
            r_send_byte <= s_axis_tdata[9:2];
        end
    end

    ps2dl_step u_step (
        .i_func      (r_func),
        .i_clk_line  (r_clk_line),
        .i_data_line (r_data_line),
        .i_send_byte (r_send_byte),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    // update the link state once per processed event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode <= MODE_IDLE;
            r_state.phase <= PH_START;
            r_state.send_pending <= 1'b0;
            r_state.tx_shift <= '0;
            r_state.bit_index <= '0;
            r_state.parity_acc <= 1'b0;
            r_state.rx_shift <= '0;
            r_state.error_bits <= '0;
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    // load the result register, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (adv) begin
            r_out <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {5'd0, r_out.link_status, r_out.tx_done, r_out.rx_errors,
                           r_out.rx_byte, r_out.rx_valid, r_out.data_level,
                           r_out.data_write, r_out.clk_level, r_out.clk_write};

    // the state moves only when an event is processed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_state))
        else $error("link state changed without an event");

    // the data bit counter never runs past the parity point
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bit_index <= 4'(LAST_BIT + 1))
        else $error("bit index out of range");

    // a completed frame always leaves the link idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.tx_done || r_out.rx_valid) |->
            r_out.link_status == MODE_IDLE && !(r_out.tx_done && r_out.rx_valid))
        else $error("frame completion with link not idle");

    // a pending send clears only together with a transmit-done result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(r_state.send_pending) |->
            r_out_valid && r_out.tx_done)
        else $error("send request dropped without tx_done");

    // no received byte or errors leak out without rx_valid
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.rx_valid |-> r_out.rx_byte == '0 && r_out.rx_errors == '0)
        else $error("receive payload without rx_valid");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PS/2 device link engine. A scoreboard class
// tracks the link state request by request and predicts each result. Tasks
// drive directed events, then random send frames, receive frames and noise,
// while the sender idles in bursts and the result side stalls on its own.
// ----------------------------------------------------------------------------
module testbench;
    import ps2dl_pkg::*;

    localparam int ITEM_TARGET = 450;
    localparam int STUCK_LIMIT = 2000;

    // Predict link results and check what comes back from the block
    class link_scoreboard;
        t_state  st;
        t_result expected_q[$];
        int      errors;

        function new();
            st = '0;
            errors = 0;
        endfunction

        // Advance the link state by one accepted request and queue its result
        function void note_event(t_event ev, logic c, logic d, logic [7:0] tx_val);
            t_result r;
            logic    lvl;
            r = '0;
            case (ev)
                EV_CLK_RISE: begin
                    if (st.mode == MODE_IDLE) begin
                        if (!c) st.mode = MODE_REQUEST;
                    end else if (st.mode == MODE_REQUEST && c) begin
                        st.mode = MODE_RECEIVE;
                        st.phase = PH_START;
                        st.bit_index = '0;
                    end
                    if (st.mode == MODE_SEND || st.mode == MODE_RECEIVE) begin
                        r.clk_write = 1'b1;
                        r.clk_level = 1'b1;
                    end
                    if (st.mode == MODE_SEND && st.phase >= PH_FINISHED) begin
                        st.mode = MODE_IDLE;
                        st.send_pending = 1'b0;
                        r.tx_done = 1'b1;
                    end
                    if (st.mode == MODE_IDLE && st.send_pending) begin
                        st.mode = MODE_SEND;
                        st.phase = PH_START;
                    end
                end
                EV_CLK_FALL: begin
                    if (st.mode == MODE_SEND || st.mode == MODE_RECEIVE) begin
                        r.clk_write = 1'b1;
                    end
                    if (st.mode == MODE_RECEIVE && st.phase >= PH_FINISHED) begin
                        st.mode = MODE_IDLE;
                        r.rx_valid = 1'b1;
                        r.rx_byte = st.rx_shift;
                        r.rx_errors = st.error_bits;
                    end
                end
                EV_DATA_TICK: begin
                    if (st.mode == MODE_SEND || st.mode == MODE_RECEIVE) begin
                        if (!c) begin
                            // clock held low by the host: release data and drop the frame
                            r.data_write = 1'b1;
                            r.data_level = 1'b1;
                            st.mode = MODE_IDLE;
                        end else if (st.mode == MODE_SEND) begin
                            r.data_write = 1'b1;
                            case (st.phase)
                                PH_START: begin
                                    st.bit_index = '0;
                                    st.parity_acc = 1'b0;
                                    r.data_level = 1'b0;
                                    st.phase = PH_DATA;
                                end
                                PH_DATA: begin
                                    lvl = st.tx_shift[st.bit_index[2:0]];
                                    st.bit_index = st.bit_index + 4'd1;
                                    st.parity_acc ^= lvl;
                                    if (st.bit_index > LAST_BIT) begin
                                        st.parity_acc ^= 1'b1;
                                        st.phase = PH_PARITY;
                                    end
                                    r.data_level = lvl;
                                end
                                PH_PARITY: begin
                                    r.data_level = st.parity_acc;
                                    st.phase = PH_STOP;
                                end
                                PH_STOP: begin
                                    r.data_level = 1'b1;
                                    st.phase = PH_FINISHED;
                                end
                                default: begin
                                    r.data_level = 1'b1;
                                end
                            endcase
                        end else begin
                            case (st.phase)
                                PH_START: begin
                                    st.bit_index = '0;
                                    st.parity_acc = 1'b0;
                                    st.error_bits = '0;
                                    st.error_bits[ERR_START] = d;
                                    st.phase = PH_DATA;
                                end
                                PH_DATA: begin
                                    st.rx_shift[st.bit_index[2:0]] = d;
                                    st.bit_index = st.bit_index + 4'd1;
                                    st.parity_acc ^= d;
                                    if (st.bit_index > LAST_BIT) begin
                                        st.parity_acc ^= 1'b1;
                                        st.phase = PH_PARITY;
                                    end
                                end
                                PH_PARITY: begin
                                    if (d != st.parity_acc) st.error_bits[ERR_PARITY] = 1'b1;
                                    st.phase = PH_STOP;
                                end
                                PH_STOP: begin
                                    if (!d) st.error_bits[ERR_STOP] = 1'b1;
                                    st.phase = PH_ACK;
                                end
                                PH_ACK: begin
                                    // ack: pull data low once
                                    r.data_write = 1'b1;
                                    st.phase = PH_FINISHED;
                                end
                                default: begin
                                    r.data_write = 1'b1;
                                    r.data_level = 1'b1;
                                end
                            endcase
                        end
                    end
                end
                default: begin
                    // hold the first latched byte until it is sent
                    if (!st.send_pending) begin
                        st.send_pending = 1'b1;
                        st.tx_shift = tx_val;
                    end
                end
            endcase
            r.link_status = st.mode;
            expected_q.push_back(r);
        endfunction

        function void check_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(logic [23:0] rd);
            t_result e;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, rd);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            check_field("clk_write", e.clk_write, rd[0]);
            check_field("clk_level", e.clk_level, rd[1]);
            check_field("data_write", e.data_write, rd[2]);
            check_field("data_level", e.data_level, rd[3]);
            check_field("rx_valid", e.rx_valid, rd[4]);
            check_field("rx_byte", e.rx_byte, rd[12:5]);
            check_field("rx_errors", e.rx_errors, rd[15:13]);
            check_field("tx_done", e.tx_done, rd[16]);
            check_field("link_status", e.link_status, rd[18:17]);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [0] clk_line, [1] data_line, [9:2] send_byte, [15:10] zero
    logic [15:0] s_axis_tdata = '0;
    // [1:0] func
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] clk_write, [1] clk_level, [2] data_write, [3] data_level,
    // [4] rx_valid, [12:5] rx_byte, [15:13] rx_errors, [16] tx_done,
    // [18:17] link_status, [23:19] zero
    logic [23:0] m_axis_tdata;

    link_scoreboard sb = new();
    int burst_left = 0;
    int sent_count = 0;
    int stuck_cycles = 0;
    int rx_window = 0;
    int rx_style = 0;

    ps2_device_link_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Random line level
    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Random byte
    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    // Stall the result side in windows of varying style
    always @(posedge i_clk) begin
        if (rx_window == 0) begin
            rx_window <= $urandom_range(16, 80);
            rx_style <= $urandom_range(0, 3);
        end else begin
            rx_window <= rx_window - 1;
        end
        case (rx_style)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ~m_axis_tready;
            default: m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Check results at the falling edge, before the rising edge that takes them
    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // Drop the run when neither side moves for too long
    always @(negedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Offer one request and wait until it is taken; idle between bursts
    task automatic send_event(t_event ev, logic c, logic d, logic [7:0] tx_val);
        bit taken;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= ev;
        s_axis_tdata <= {6'd0, tx_val, d, c};
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        sb.note_event(ev, c, d, tx_val);
        sent_count++;
    endtask

    // Cancel whatever frame is in flight so the next run starts idle
    task automatic drop_link();
        while (sb.st.mode != MODE_IDLE) begin
            if (sb.st.mode == MODE_REQUEST) begin
                send_event(EV_CLK_RISE, 1'b1, rand_bit(), rand_byte());
            end else begin
                send_event(EV_DATA_TICK, 1'b0, rand_bit(), rand_byte());
            end
        end
    endtask

    // One full clock pulse between data ticks
    task automatic clock_cycle();
        send_event(EV_CLK_FALL, rand_bit(), rand_bit(), rand_byte());
        send_event(EV_CLK_RISE, 1'b1, rand_bit(), rand_byte());
    endtask

    // Latch a byte and shift it out, sometimes cancelled midway
    task automatic run_send_frame();
        logic [7:0] v;
        bit         full;
        int         ticks;
        drop_link();
        v = rand_byte();
        full = ($urandom_range(0, 3) == 0);
        send_event(EV_SEND_REQ, rand_bit(), rand_bit(), v);
        if ($urandom_range(0, 5) == 0) begin
            send_event(EV_SEND_REQ, rand_bit(), rand_bit(), rand_byte());
        end
        send_event(EV_CLK_RISE, 1'b1, rand_bit(), rand_byte());
        ticks = 11 + $urandom_range(0, 2);
        for (int k = 0; k < ticks; k++) begin
            if ($urandom_range(0, 39) == 0) begin
                send_event(EV_DATA_TICK, 1'b0, rand_bit(), rand_byte());
                return;
            end
            send_event(EV_DATA_TICK, 1'b1, rand_bit(), rand_byte());
            if (full && k < ticks - 1) clock_cycle();
        end
        send_event(EV_CLK_RISE, 1'b1, rand_bit(), rand_byte());
    endtask

    // Host request, then a frame with occasional start/parity/stop errors
    task automatic run_receive_frame();
        logic [7:0]  v;
        logic [10:0] frame_bits;
        bit          full;
        int          ticks;
        drop_link();
        v = rand_byte();
        full = ($urandom_range(0, 3) == 0);
        // start, data LSB first, odd parity, stop
        frame_bits = {($urandom_range(0, 7) != 0), (~^v) ^ ($urandom_range(0, 5) == 0),
                      v, ($urandom_range(0, 7) == 0)};
        send_event(EV_CLK_RISE, 1'b0, rand_bit(), rand_byte());
        if ($urandom_range(0, 1) == 0) begin
            send_event(EV_DATA_TICK, 1'b1, rand_bit(), rand_byte());
        end
        send_event(EV_CLK_RISE, 1'b1, rand_bit(), rand_byte());
        ticks = 12 + $urandom_range(0, 1);
        for (int k = 0; k < ticks; k++) begin
            if ($urandom_range(0, 39) == 0) begin
                send_event(EV_DATA_TICK, 1'b0, rand_bit(), rand_byte());
                return;
            end
            send_event(EV_DATA_TICK, 1'b1,
                       (k < 11) ? frame_bits[k] : rand_bit(), rand_byte());
            if (full) clock_cycle();
        end
        send_event(EV_CLK_FALL, rand_bit(), rand_bit(), rand_byte());
    endtask

    // Short bursts of fully random events
    task automatic run_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            send_event(t_event'($urandom_range(0, 3)), rand_bit(),
                       rand_bit(), rand_byte());
        end
    endtask

    initial begin
        int pick;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle events change nothing
        send_event(EV_DATA_TICK, 1'b1, 1'b0, 8'h00);
        send_event(EV_CLK_FALL, 1'b0, 1'b1, 8'h00);
        // latch a byte; a second request is ignored while one is pending
        send_event(EV_SEND_REQ, 1'b1, 1'b1, 8'hFF);
        send_event(EV_SEND_REQ, 1'b0, 1'b0, 8'h00);
        // start sending, then cancel right after the start bit
        send_event(EV_CLK_RISE, 1'b1, 1'b0, 8'h00);
        send_event(EV_DATA_TICK, 1'b1, 1'b0, 8'h00);
        send_event(EV_DATA_TICK, 1'b0, 1'b1, 8'hFF);
        // retry the pending byte with one tick past the stop bit
        send_event(EV_CLK_RISE, 1'b1, 1'b1, 8'hFF);
        repeat (12) send_event(EV_DATA_TICK, 1'b1, 1'b1, 8'hFF);
        send_event(EV_CLK_RISE, 1'b1, 1'b0, 8'h00);
        // host request with a tick in between, then enter receive
        send_event(EV_CLK_RISE, 1'b0, 1'b0, 8'h00);
        send_event(EV_DATA_TICK, 1'b1, 1'b0, 8'h00);
        send_event(EV_CLK_RISE, 1'b1, 1'b1, 8'hFF);

        // random mix, mostly well-formed frames
        while (sent_count < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) run_send_frame();
            else if (pick < 8) run_receive_frame();
            else run_noise();
        end
        s_axis_tvalid <= 1'b0;

        // drain outstanding results, then let the pipeline settle
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
